// File: sv/lbm_pkg.sv
`default_nettype none
package lbm_pkg;

   // fixed point format
   localparam int FRAC_BITS = 24;
   localparam int IN_W      = 32;

   // moment widths: nine 32 bit terms for density, six for each momentum
   localparam int RHO_W = 36;
   localparam int MOM_W = 35;
   localparam int DEN_W = RHO_W - 1;
   localparam int MAG_W = MOM_W - 1;

   // pipeline depths
   localparam int DIV_BITS  = MAG_W + FRAC_BITS;
   localparam int DIV_LAT   = DIV_BITS + 2;
   localparam int MUL_LAT   = 4;
   localparam int POLY_LAT  = 3;
   localparam int LANE_LAT  = 1 + MUL_LAT + POLY_LAT + MUL_LAT + 1;
   localparam int MERGE_LAT = 3 + MUL_LAT + 1;
   localparam int TOTAL_LAT = 1 + DIV_LAT + LANE_LAT + MERGE_LAT;

   // one lane per moving direction, the rest direction adds nothing to the stress
   localparam int LANES      = 8;
   localparam int LANE_IDX_W = 4;

   typedef logic signed [63:0] q64_type;

   localparam q64_type SAT64  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam q64_type MIN64  = 64'sh8000_0000_0000_0000;
   localparam q64_type ONE_Q  = 64'sd1 << FRAC_BITS;
   localparam q64_type W_REST = ((64'sd8 << FRAC_BITS) + 64'sd9) / 64'sd18;
   localparam q64_type W_AXIS = ((64'sd2 << FRAC_BITS) + 64'sd9) / 64'sd18;
   localparam q64_type W_DIAG = ((64'sd2 << FRAC_BITS) + 64'sd36) / 64'sd72;

   // direction codes
   localparam logic [LANE_IDX_W-1:0] DIR_REST      = 4'd0;
   localparam logic [LANE_IDX_W-1:0] DIR_EAST      = 4'd1;
   localparam logic [LANE_IDX_W-1:0] DIR_NORTH     = 4'd2;
   localparam logic [LANE_IDX_W-1:0] DIR_WEST      = 4'd3;
   localparam logic [LANE_IDX_W-1:0] DIR_SOUTH     = 4'd4;
   localparam logic [LANE_IDX_W-1:0] DIR_NORTHEAST = 4'd5;
   localparam logic [LANE_IDX_W-1:0] DIR_NORTHWEST = 4'd6;
   localparam logic [LANE_IDX_W-1:0] DIR_SOUTHWEST = 4'd7;
   localparam logic [LANE_IDX_W-1:0] DIR_SOUTHEAST = 4'd8;

   // register map
   localparam int   CSR_ADDR_W       = 3;
   localparam logic REG_STRESS_SCALE = 1'b0;
   localparam logic signed [31:0] SCALE_RESET = -32'sd83886080;

   typedef struct packed {
      logic signed [IN_W-1:0] f_rest;
      logic signed [IN_W-1:0] f_east;
      logic signed [IN_W-1:0] f_north;
      logic signed [IN_W-1:0] f_west;
      logic signed [IN_W-1:0] f_south;
      logic signed [IN_W-1:0] f_northeast;
      logic signed [IN_W-1:0] f_northwest;
      logic signed [IN_W-1:0] f_southwest;
      logic signed [IN_W-1:0] f_southeast;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] s_xx;
      logic signed [31:0] s_xy;
      logic signed [31:0] s_yx;
      logic signed [31:0] s_yy;
      logic               density_error;
   } rsp_word_type;

   function automatic q64_type sat_add(input q64_type a, input q64_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > $signed({1'b0, SAT64}))
         return SAT64;
      if (s < -$signed({1'b0, SAT64}))
         return -SAT64;
      return s[63:0];
   endfunction

   function automatic q64_type sat_neg(input q64_type a);
      if (a == MIN64)
         return SAT64;
      return -a;
   endfunction

   function automatic logic signed [1:0] dir_x(input logic [LANE_IDX_W-1:0] idx);
      unique case (idx) inside
         DIR_EAST, DIR_NORTHEAST, DIR_SOUTHEAST: return 2'sd1;
         DIR_WEST, DIR_NORTHWEST, DIR_SOUTHWEST: return -2'sd1;
         default:                                 return 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] dir_y(input logic [LANE_IDX_W-1:0] idx);
      unique case (idx) inside
         DIR_NORTH, DIR_NORTHEAST, DIR_NORTHWEST: return 2'sd1;
         DIR_SOUTH, DIR_SOUTHWEST, DIR_SOUTHEAST: return -2'sd1;
         default:                                 return 2'sd0;
      endcase
   endfunction

   function automatic q64_type lane_weight(input logic [LANE_IDX_W-1:0] idx);
      unique case (idx) inside
         DIR_REST:                                      return W_REST;
         DIR_EAST, DIR_NORTH, DIR_WEST, DIR_SOUTH:      return W_AXIS;
         default:                                       return W_DIAG;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: sv/lbm_qmul.sv
`default_nettype none
module lbm_qmul import lbm_pkg::*; (
   input  logic    clock,
   input  q64_type a,
   input  q64_type b,
   output q64_type p
);

   logic          neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]   x_ff, y_ff;
   logic [63:0]   p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0]  prod_ff;
   q64_type       p_ff;

   logic [127:0]  prod_in;
   logic [63:0]   r;
   q64_type       p_in;

   always_comb begin
      prod_in = {p11_ff, 64'd0} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
              + {64'd0, p00_ff};
      // magnitude truncated, then saturated
      if (|prod_ff[127:FRAC_BITS+63])
         r = SAT64;
      else
         r = prod_ff[FRAC_BITS+63:FRAC_BITS];
      p_in = neg3_ff ? -q64_type'(r) : q64_type'(r);
   end

   always_ff @(posedge clock) begin
      neg1_ff <= a[63] ^ b[63];
      x_ff    <= a[63] ? 64'(-a) : 64'(a);
      y_ff    <= b[63] ? 64'(-b) : 64'(b);
      neg2_ff <= neg1_ff;
      p00_ff  <= x_ff[31:0]  * y_ff[31:0];
      p01_ff  <= x_ff[31:0]  * y_ff[63:32];
      p10_ff  <= x_ff[63:32] * y_ff[31:0];
      p11_ff  <= x_ff[63:32] * y_ff[63:32];
      neg3_ff <= neg2_ff;
      prod_ff <= prod_in;
      p_ff    <= p_in;
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// File: sv/lbm_div.sv
`default_nettype none
module lbm_div import lbm_pkg::*; (
   input  logic                    clock,
   input  logic signed [MOM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output q64_type                 quo
);

   // one quotient bit per stage, restoring
   logic [DEN_W-1:0]    rem_ff [DIV_BITS];
   logic [DIV_BITS-1:0] n_ff   [DIV_BITS];
   logic [DEN_W-1:0]    d_ff   [DIV_BITS];
   logic [DIV_BITS-1:0] q_ff   [DIV_BITS+1];
   logic                neg_ff [DIV_BITS+1];
   q64_type             quo_ff;

   logic [MOM_W-1:0]    mag_in;
   logic [63:0]         qz;

   always_comb begin
      mag_in = num[MOM_W-1] ? MOM_W'(-num) : MOM_W'(num);
      qz     = 64'(q_ff[DIV_BITS]);
      if (qz[63])
         qz = SAT64;
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      n_ff[0]   <= {mag_in[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      d_ff[0]   <= den;
      q_ff[0]   <= '0;
      neg_ff[0] <= num[MOM_W-1];
      quo_ff    <= neg_ff[DIV_BITS] ? -q64_type'(qz) : q64_type'(qz);
   end

   for (genvar s = 1; s <= DIV_BITS; s++) begin : g_stage
      logic [DEN_W:0] trial;
      logic           ge;

      always_comb begin
         trial = {rem_ff[s-1], n_ff[s-1][DIV_BITS-1]};
         ge    = trial >= {1'b0, d_ff[s-1]};
      end

      always_ff @(posedge clock) begin
         q_ff[s]   <= {q_ff[s-1][DIV_BITS-2:0], ge};
         neg_ff[s] <= neg_ff[s-1];
      end

      if (s < DIV_BITS) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s] <= ge ? DEN_W'(trial - {1'b0, d_ff[s-1]}) : trial[DEN_W-1:0];
            n_ff[s]   <= n_ff[s-1] << 1;
            d_ff[s]   <= d_ff[s-1];
         end
      end
   end

   assign quo = quo_ff;

endmodule
`default_nettype wire

// File: sv/lbm_lane.sv
`default_nettype none
module lbm_lane import lbm_pkg::*; (
   input  logic                   clock,
   input  logic [LANE_IDX_W-1:0]  lane_idx,
   input  q64_type                u,
   input  q64_type                v,
   input  q64_type                rho,
   input  logic signed [IN_W-1:0] f,
   input  q64_type                uv,
   output q64_type                fneq
);

   localparam int WRHO_DLY = 1 + POLY_LAT;
   localparam int F_DLY    = LANE_LAT - 1;
   localparam logic [3:0] K_THREE = 4'd3;
   localparam logic [3:0] K_NINE  = 4'd9;

   // k*|x| >> sh, saturated, sign of x
   function automatic q64_type qconst(input q64_type x, input logic [3:0] k, input logic sh);
      logic [63:0] m;
      logic [67:0] pr;
      logic [67:0] r;
      logic [63:0] rm;
      m  = x[63] ? 64'(-x) : 64'(x);
      pr = 68'(m) * 68'(k);
      r  = sh ? (pr >> 1) : pr;
      rm = (r > 68'(SAT64)) ? SAT64 : r[63:0];
      return x[63] ? -q64_type'(rm) : q64_type'(rm);
   endfunction

   logic signed [1:0]      dx, dy;
   q64_type                xterm, yterm, eu_in;
   q64_type                eu_ff;
   q64_type                eu_dly_ff   [MUL_LAT];
   q64_type                wrho_dly_ff [WRHO_DLY];
   logic signed [IN_W-1:0] f_dly_ff    [F_DLY];
   q64_type                ee, wrho, feq;
   q64_type                p1_ff, t45_ff, t15_ff, p2_ff, t15_d_ff, poly_ff, fneq_ff;

   always_comb begin
      dx = dir_x(lane_idx);
      dy = dir_y(lane_idx);
      xterm = '0;
      yterm = '0;
      if (dx > 0) xterm = u;
      if (dx < 0) xterm = sat_neg(u);
      if (dy > 0) yterm = v;
      if (dy < 0) yterm = sat_neg(v);
      eu_in = sat_add(xterm, yterm);
   end

   lbm_qmul u_ee   (.clock(clock), .a(eu_ff), .b(eu_ff), .p(ee));
   lbm_qmul u_wrho (.clock(clock), .a(lane_weight(lane_idx)), .b(rho), .p(wrho));
   lbm_qmul u_feq  (.clock(clock), .a(wrho_dly_ff[WRHO_DLY-1]), .b(poly_ff), .p(feq));

   always_ff @(posedge clock) begin
      eu_ff <= eu_in;
      eu_dly_ff[0] <= eu_ff;
      for (int i = 1; i < MUL_LAT; i++)
         eu_dly_ff[i] <= eu_dly_ff[i-1];
      wrho_dly_ff[0] <= wrho;
      for (int i = 1; i < WRHO_DLY; i++)
         wrho_dly_ff[i] <= wrho_dly_ff[i-1];
      f_dly_ff[0] <= f;
      for (int i = 1; i < F_DLY; i++)
         f_dly_ff[i] <= f_dly_ff[i-1];

      // second order polynomial, one saturating add per stage
      p1_ff    <= sat_add(ONE_Q, qconst(eu_dly_ff[MUL_LAT-1], K_THREE, 1'b0));
      t45_ff   <= qconst(ee, K_NINE, 1'b1);
      t15_ff   <= qconst(uv, K_THREE, 1'b1);
      p2_ff    <= sat_add(p1_ff, t45_ff);
      t15_d_ff <= t15_ff;
      poly_ff  <= sat_add(p2_ff, sat_neg(t15_d_ff));

      fneq_ff <= sat_add(q64_type'(f_dly_ff[F_DLY-1]), sat_neg(feq));
   end

   assign fneq = fneq_ff;

endmodule
`default_nettype wire

// File: sv/lbm_merge.sv
`default_nettype none
module lbm_merge import lbm_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] scale,
   input  logic               err_in,
   input  q64_type            fneq [LANES],
   output rsp_word_type       word
);

   localparam int ERR_DLY = 3 + MUL_LAT;

   function automatic logic signed [31:0] sat32(input q64_type s);
      if (s > 64'sd2147483647)
         return 32'sh7FFF_FFFF;
      if (s < -64'sd2147483648)
         return 32'sh8000_0000;
      return s[31:0];
   endfunction

   q64_type      sxx1_ff, syy1_ff, sxy1_ff, sxx2_ff, syy2_ff, sxy2_ff;
   q64_type      sxx3_ff, syy3_ff, sxy3_ff;
   q64_type      f5_ff, f6_ff, f7_ff, f8_ff, f7_d_ff, f8_d_ff;
   q64_type      scale64;
   q64_type      pxx, pxy, pyy;
   logic         err_dly_ff [ERR_DLY];
   rsp_word_type word_ff;

   assign scale64 = q64_type'(scale);

   lbm_qmul u_xx (.clock(clock), .a(scale64), .b(sxx3_ff), .p(pxx));
   lbm_qmul u_xy (.clock(clock), .a(scale64), .b(sxy3_ff), .p(pxy));
   lbm_qmul u_yy (.clock(clock), .a(scale64), .b(syy3_ff), .p(pyy));

   // sums kept in direction order, saturation is not associative
   always_ff @(posedge clock) begin
      sxx1_ff <= sat_add(fneq[0], fneq[2]);
      syy1_ff <= sat_add(fneq[1], fneq[3]);
      sxy1_ff <= sat_add(fneq[4], sat_neg(fneq[5]));
      f5_ff   <= fneq[4];
      f6_ff   <= fneq[5];
      f7_ff   <= fneq[6];
      f8_ff   <= fneq[7];

      sxx2_ff <= sat_add(sat_add(sxx1_ff, f5_ff), f6_ff);
      syy2_ff <= sat_add(sat_add(syy1_ff, f5_ff), f6_ff);
      sxy2_ff <= sat_add(sxy1_ff, f7_ff);
      f7_d_ff <= f7_ff;
      f8_d_ff <= f8_ff;

      sxx3_ff <= sat_add(sat_add(sxx2_ff, f7_d_ff), f8_d_ff);
      syy3_ff <= sat_add(sat_add(syy2_ff, f7_d_ff), f8_d_ff);
      sxy3_ff <= sat_add(sxy2_ff, sat_neg(f8_d_ff));

      err_dly_ff[0] <= err_in;
      for (int i = 1; i < ERR_DLY; i++)
         err_dly_ff[i] <= err_dly_ff[i-1];

      if (err_dly_ff[ERR_DLY-1]) begin
         word_ff <= '{s_xx: '0, s_xy: '0, s_yx: '0, s_yy: '0, density_error: 1'b1};
      end else begin
         word_ff.s_xx          <= sat32(pxx);
         word_ff.s_xy          <= sat32(pxy);
         word_ff.s_yx          <= sat32(pxy);
         word_ff.s_yy          <= sat32(pyy);
         word_ff.density_error <= 1'b0;
      end
   end

   assign word = word_ff;

endmodule
`default_nettype wire

// File: sv/lbm_d2q9_stress_from_nonequilibrium_core.sv
`default_nettype none
// d2q9 stress from the non-equilibrium distributions, one lattice cell per word.
// a word is taken at every clock edge where start is high and busy is low; busy is
// high while reset is held and in the cycle after, so a new cell can enter every
// cycle. each cell gives exactly one result word on rsp_word, marked by rsp_strobe
// for one cycle; distributions are in Q8.24 at the default FRAC_BITS. the receiver
// cannot stall: results must be taken as they come. the latency is set mostly by
// the velocity dividers, which resolve one quotient bit per pipeline stage; eight
// direction lanes then form the equilibrium and non-equilibrium parts in parallel
// and a merge stage sums them into the stress components and applies stress_scale.
// a cell with density zero or below gives a result with density_error set and all
// stresses zero. stress_scale (byte address 0 of the apb port) should only be
// written while no cell is in flight.
module lbm_d2q9_stress_from_nonequilibrium_core import lbm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // cell input
   input  logic                  start,
   output logic                  busy,
   input  req_word_type          req_word,
   // result output
   output logic                  rsp_strobe,
   output rsp_word_type          rsp_word,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   typedef struct packed {
      logic [LANES-1:0][IN_W-1:0] f;
      logic signed [RHO_W-1:0]    rho;
   } side_type;

   localparam int ERR_DLY = DIV_LAT + LANE_LAT;

   // control
   logic               busy_ff;
   logic               accept;
   logic               valid_ff [TOTAL_LAT];
   logic signed [31:0] scale_ff;

   // moments stage
   side_type                side_in, side_a_ff;
   logic signed [MOM_W-1:0] mx_in, my_in, mx_a_ff, my_a_ff;
   logic                    err_a_ff;

   // side data waiting for the dividers
   side_type side_dly_ff [DIV_LAT];
   logic     err_dly_ff  [ERR_DLY];

   q64_type u_q, v_q, uu, vv, uv_ff, rho64;
   q64_type fneq [LANES];

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // density and momentum from the nine distributions
   always_comb begin
      side_in.f   = {req_word.f_southeast, req_word.f_southwest, req_word.f_northwest,
                     req_word.f_northeast, req_word.f_south, req_word.f_west,
                     req_word.f_north, req_word.f_east};
      side_in.rho = RHO_W'($signed(req_word.f_rest)) + RHO_W'($signed(req_word.f_east))
                  + RHO_W'($signed(req_word.f_north)) + RHO_W'($signed(req_word.f_west))
                  + RHO_W'($signed(req_word.f_south))
                  + RHO_W'($signed(req_word.f_northeast))
                  + RHO_W'($signed(req_word.f_northwest))
                  + RHO_W'($signed(req_word.f_southwest))
                  + RHO_W'($signed(req_word.f_southeast));
      mx_in = MOM_W'($signed(req_word.f_east)) - MOM_W'($signed(req_word.f_west))
            + MOM_W'($signed(req_word.f_northeast)) - MOM_W'($signed(req_word.f_northwest))
            - MOM_W'($signed(req_word.f_southwest)) + MOM_W'($signed(req_word.f_southeast));
      my_in = MOM_W'($signed(req_word.f_north)) - MOM_W'($signed(req_word.f_south))
            + MOM_W'($signed(req_word.f_northeast)) + MOM_W'($signed(req_word.f_northwest))
            - MOM_W'($signed(req_word.f_southwest)) - MOM_W'($signed(req_word.f_southeast));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         scale_ff <= SCALE_RESET;
         for (int i = 0; i < TOTAL_LAT; i++)
            valid_ff[i] <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         if (psel && penable && pwrite && paddr[2] == REG_STRESS_SCALE)
            scale_ff <= pwdata;
         valid_ff[0] <= accept;
         for (int i = 1; i < TOTAL_LAT; i++)
            valid_ff[i] <= valid_ff[i-1];
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      side_a_ff <= side_in;
      mx_a_ff   <= mx_in;
      my_a_ff   <= my_in;
      err_a_ff  <= side_in.rho <= 0;

      side_dly_ff[0] <= side_a_ff;
      for (int i = 1; i < DIV_LAT; i++)
         side_dly_ff[i] <= side_dly_ff[i-1];
      err_dly_ff[0] <= err_a_ff;
      for (int i = 1; i < ERR_DLY; i++)
         err_dly_ff[i] <= err_dly_ff[i-1];

      uv_ff <= sat_add(uu, vv);
   end

   // velocity, a garbage quotient for non-positive density is masked by the error
   lbm_div u_div_u (.clock(clock), .num(mx_a_ff), .den(side_a_ff.rho[DEN_W-1:0]), .quo(u_q));
   lbm_div u_div_v (.clock(clock), .num(my_a_ff), .den(side_a_ff.rho[DEN_W-1:0]), .quo(v_q));

   // u^2 + v^2 is shared by all lanes
   lbm_qmul u_uu (.clock(clock), .a(u_q), .b(u_q), .p(uu));
   lbm_qmul u_vv (.clock(clock), .a(v_q), .b(v_q), .p(vv));

   assign rho64 = q64_type'(side_dly_ff[DIV_LAT-1].rho);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      lbm_lane u_lane (
         .clock    (clock),
         .lane_idx (LANE_IDX_W'(i + 1)),
         .u        (u_q),
         .v        (v_q),
         .rho      (rho64),
         .f        ($signed(side_dly_ff[DIV_LAT-1].f[i])),
         .uv       (uv_ff),
         .fneq     (fneq[i])
      );
   end

   lbm_merge u_merge (
      .clock  (clock),
      .scale  (scale_ff),
      .err_in (err_dly_ff[ERR_DLY-1]),
      .fneq   (fneq),
      .word   (rsp_word)
   );

   assign rsp_strobe = valid_ff[TOTAL_LAT-1];
   assign prdata     = (paddr[2] == REG_STRESS_SCALE) ? scale_ff : 32'd0;
   assign pready     = 1'b1;

   // every taken cell comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TOTAL_LAT rsp_strobe)
      else $error("result word missing after fixed latency");

   // bad density forces zero stresses
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.density_error) |->
         (rsp_word.s_xx == 0 && rsp_word.s_xy == 0 && rsp_word.s_yy == 0))
      else $error("stress not cleared on density error");

   // stress tensor stays symmetric
   a_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_word.s_yx == rsp_word.s_xy)
      else $error("s_yx differs from s_xy");

endmodule
`default_nettype wire
